FILE: rtl/core/rmte_pkg.sv
package rmte_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int CW = 36;
  localparam int ZW = 25;
  localparam int PW = 34;

  localparam logic signed [ZW-1:0] PI_Q20 = 25'sd3294199;
  localparam logic [57:0] ONE_Q56 = 58'd1 << 56;
  localparam logic signed [PW-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [PW-1:0] NEG_ONE_Q28 = -34'sd268435456;
  localparam logic signed [17:0] ROLL_LIM = 18'sd25736;
  localparam logic signed [17:0] PITCH_LIM = 18'sd12868;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'sd823550, 25'sd486170, 25'sd256879, 25'sd130396, 25'sd65451,
    25'sd32757, 25'sd16383, 25'sd8192, 25'sd4096, 25'sd2048,
    25'sd1024, 25'sd512, 25'sd256, 25'sd128, 25'sd64,
    25'sd32, 25'sd16, 25'sd8, 25'sd4, 25'sd2
  };

  typedef struct packed {
    logic [14:0]        w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    quat_t                q;
    logic signed [PW-1:0] num_r;
    logic signed [PW-1:0] den_r;
    logic signed [PW-1:0] num_y;
    logic signed [PW-1:0] den_y;
    logic signed [29:0]   s;
  } carry_t;

endpackage

FILE: rtl/core/rmte_isqrt.sv
module rmte_isqrt #(
  parameter int IN_W = 30,
  parameter int LANES = 1,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [LANES-1:0][IN_W-1:0]        rad,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic [LANES-1:0][IN_W/2-1:0]      root,
  output logic [SIDE_W-1:0]                 side_out
);

  localparam int P = IN_W / 2;
  localparam int RW = P + 2;

  logic [P-1:0][LANES-1:0][IN_W-1:0] rad_q;
  logic [P-1:0][LANES-1:0][RW-1:0]   rem_q;
  logic [P-1:0][LANES-1:0][P-1:0]    root_q;
  logic [P-1:0][SIDE_W-1:0]          side_q;
  logic [P-1:0]                      vld_q;

  for (genvar s = 0; s < P; s++) begin : g_stage
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;

    if (s == 0) begin : g_first
      assign side_p = side_in;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign side_p = side_q[s-1];
      assign vld_p  = vld_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [IN_W-1:0] rad_p;
      logic [RW-1:0]   rem_p;
      logic [P-1:0]    root_p;
      logic [RW-1:0]   rem2;
      logic [RW:0]     diff;

      if (s == 0) begin : g_first
        assign rad_p  = rad[l];
        assign rem_p  = '0;
        assign root_p = '0;
      end else begin : g_next
        assign rad_p  = rad_q[s-1][l];
        assign rem_p  = rem_q[s-1][l];
        assign root_p = root_q[s-1][l];
      end

      always_comb begin
        rem2 = {rem_p[RW-3:0], rad_p[IN_W-1 -: 2]};
        diff = {1'b0, rem2} - {1'b0, root_p, 2'b01};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[s][l] <= rad_p << 2;
          if (!diff[RW]) begin
            rem_q[s][l]  <= diff[RW-1:0];
            root_q[s][l] <= {root_p[P-2:0], 1'b1};
          end else begin
            rem_q[s][l]  <= rem2;
            root_q[s][l] <= {root_p[P-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[s] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_p;
      end
    end
  end

  assign out_valid = vld_q[P-1];
  assign root      = root_q[P-1];
  assign side_out  = side_q[P-1];

endmodule

FILE: rtl/core/rmte_cordic.sv
module rmte_cordic #(
  parameter int LANES = 3,
  parameter int SIDE_W = 1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [LANES-1:0][rmte_pkg::CW-1:0]       y_in,
  input  logic [LANES-1:0][rmte_pkg::CW-1:0]       x_in,
  input  logic [SIDE_W-1:0]                        side_in,
  output logic                                     out_valid,
  output logic [LANES-1:0][rmte_pkg::ZW-1:0]       z_out,
  output logic [SIDE_W-1:0]                        side_out
);

  localparam int N = rmte_pkg::CORDIC_STEPS;

  logic [N:0][LANES-1:0][rmte_pkg::CW-1:0] x_q;
  logic [N:0][LANES-1:0][rmte_pkg::CW-1:0] y_q;
  logic [N:0][LANES-1:0][rmte_pkg::ZW-1:0] z_q;
  logic [N:0][LANES-1:0]                   zero_q;
  logic [N:0][SIDE_W-1:0]                  side_q;
  logic [N:0]                              vld_q;

  // pre-rotation into the right half plane
  for (genvar l = 0; l < LANES; l++) begin : g_pre
    logic signed [rmte_pkg::CW-1:0] xs;
    logic signed [rmte_pkg::CW-1:0] ys;
    assign xs = $signed(x_in[l]);
    assign ys = $signed(y_in[l]);

    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[0][l] <= (xs == '0) && (ys == '0);
        if (xs < 0) begin
          x_q[0][l] <= -xs;
          y_q[0][l] <= -ys;
          z_q[0][l] <= (ys >= 0) ? rmte_pkg::PI_Q20 : -rmte_pkg::PI_Q20;
        end else begin
          x_q[0][l] <= xs;
          y_q[0][l] <= ys;
          z_q[0][l] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N-1:0], in_valid};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [rmte_pkg::CW-1:0] xp;
      logic signed [rmte_pkg::CW-1:0] yp;
      logic signed [rmte_pkg::ZW-1:0] zp;
      logic signed [rmte_pkg::CW-1:0] dx;
      logic signed [rmte_pkg::CW-1:0] dy;
      assign xp = $signed(x_q[i][l]);
      assign yp = $signed(y_q[i][l]);
      assign zp = $signed(z_q[i][l]);
      assign dx = yp >>> i;
      assign dy = xp >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          zero_q[i+1][l] <= zero_q[i][l];
          if (yp >= 0) begin
            x_q[i+1][l] <= xp + dx;
            y_q[i+1][l] <= yp - dy;
            z_q[i+1][l] <= zp + rmte_pkg::ATAN_TAB[i];
          end else begin
            x_q[i+1][l] <= xp - dx;
            y_q[i+1][l] <= yp + dy;
            z_q[i+1][l] <= zp - rmte_pkg::ATAN_TAB[i];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i+1] <= side_q[i];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign z_out[l] = zero_q[N][l] ? '0 : z_q[N][l];
  end

  assign out_valid = vld_q[N];
  assign side_out  = side_q[N];

endmodule

FILE: rtl/core/rotation_matrix_to_euler_angles.sv
// Rotation matrix to quaternion and Euler angles.
// Input channel: in_valid/in_ready with the nine Q2.14 matrix entries m00..m22.
// Output channel: out_valid/out_ready with quat_w/x/y/z (Q2.14) and
// roll_angle, yaw_angle (Q3.13 radians) and pitch_angle (Q2.13 radians).
// Throughput: one item per cycle while the receiver does not stall.
// The depth is set by a 15-stage square root for the quaternion magnitudes,
// a 29-stage square root for the asin cosine term and a 21-stage CORDIC atan2
// unit shared in three lanes.
// The whole pipeline advances on one enable; in_ready is high when the output
// register is empty or being taken in that cycle.
// When out_ready is low with a result shown, every stage holds and in_ready drops;
// nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module rotation_matrix_to_euler_angles (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  localparam int CW = rmte_pkg::CW;
  localparam int ZW = rmte_pkg::ZW;
  localparam int PW = rmte_pkg::PW;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: trace combinations and signs
  logic signed [18:0] tw, tx, ty, tz;
  logic signed [16:0] dxs, dys, dzs;
  logic [3:0][16:0]   t_q;
  logic [2:0]         sgn_q;
  logic               a_vld;

  always_comb begin
    tw  = 19'sd16384 + 19'(m00) + 19'(m11) + 19'(m22);
    tx  = 19'sd16384 + 19'(m00) - 19'(m11) - 19'(m22);
    ty  = 19'sd16384 - 19'(m00) + 19'(m11) - 19'(m22);
    tz  = 19'sd16384 - 19'(m00) - 19'(m11) + 19'(m22);
    dxs = 17'(m21) - 17'(m12);
    dys = 17'(m02) - 17'(m20);
    dzs = 17'(m10) - 17'(m01);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_q[0] <= (tw < 0) ? '0 : tw[16:0];
      t_q[1] <= (tx < 0) ? '0 : tx[16:0];
      t_q[2] <= (ty < 0) ? '0 : ty[16:0];
      t_q[3] <= (tz < 0) ? '0 : tz[16:0];
      sgn_q  <= {dzs < 0, dys < 0, dxs < 0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  logic [3:0][29:0] q_rad;
  logic [3:0][14:0] q_root;
  logic [2:0]       q_sgn;
  logic             q_vld;

  for (genvar l = 0; l < 4; l++) begin : g_qrad
    assign q_rad[l] = {1'b0, t_q[l], 12'b0};
  end

  rmte_isqrt #(.IN_W(30), .LANES(4), .SIDE_W(3)) u_qsqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(a_vld), .rad(q_rad), .side_in(sgn_q),
    .out_valid(q_vld), .root(q_root), .side_out(q_sgn)
  );

  // stage Q: signed quaternion
  rmte_pkg::quat_t quat_q;
  logic            b_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      quat_q.w <= q_root[0];
      quat_q.x <= q_sgn[0] ? -$signed({1'b0, q_root[1]}) : $signed({1'b0, q_root[1]});
      quat_q.y <= q_sgn[1] ? -$signed({1'b0, q_root[2]}) : $signed({1'b0, q_root[2]});
      quat_q.z <= q_sgn[2] ? -$signed({1'b0, q_root[3]}) : $signed({1'b0, q_root[3]});
    end
  end

  // stage C: products
  logic signed [15:0] ws;
  logic signed [31:0] p_wx, p_yz, p_wy, p_zx, p_wz, p_xy, p_xx, p_yy, p_zz;
  rmte_pkg::quat_t    quat_c;
  logic               c_vld;

  assign ws = $signed({1'b0, quat_q.w});

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx   <= ws * quat_q.x;
      p_yz   <= quat_q.y * quat_q.z;
      p_wy   <= ws * quat_q.y;
      p_zx   <= quat_q.z * quat_q.x;
      p_wz   <= ws * quat_q.z;
      p_xy   <= quat_q.x * quat_q.y;
      p_xx   <= quat_q.x * quat_q.x;
      p_yy   <= quat_q.y * quat_q.y;
      p_zz   <= quat_q.z * quat_q.z;
      quat_c <= quat_q;
    end
  end

  // stage D: atan2 operands and clamped asin argument
  logic signed [PW-1:0] s_raw;
  rmte_pkg::carry_t     d_q;
  logic                 d_vld;

  assign s_raw = (PW'(p_wy) - PW'(p_zx)) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      d_q.q     <= quat_c;
      d_q.num_r <= (PW'(p_wx) + PW'(p_yz)) <<< 1;
      d_q.den_r <= rmte_pkg::ONE_Q28 - ((PW'(p_xx) + PW'(p_yy)) <<< 1);
      d_q.num_y <= (PW'(p_wz) + PW'(p_xy)) <<< 1;
      d_q.den_y <= rmte_pkg::ONE_Q28 - ((PW'(p_yy) + PW'(p_zz)) <<< 1);
      if (s_raw > rmte_pkg::ONE_Q28) begin
        d_q.s <= 30'(rmte_pkg::ONE_Q28);
      end else if (s_raw < rmte_pkg::NEG_ONE_Q28) begin
        d_q.s <= 30'(rmte_pkg::NEG_ONE_Q28);
      end else begin
        d_q.s <= s_raw[29:0];
      end
    end
  end

  // stage E: partial squares of |s|
  logic [29:0]      s_abs;
  logic [27:0]      pp_hh;
  logic [28:0]      pp_hl;
  logic [29:0]      pp_ll;
  rmte_pkg::carry_t e_q;
  logic             e_vld;

  assign s_abs = d_q.s[29] ? 30'(-d_q.s) : 30'(d_q.s);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= s_abs[28:15] * s_abs[28:15];
      pp_hl <= s_abs[28:15] * s_abs[14:0];
      pp_ll <= s_abs[14:0] * s_abs[14:0];
      e_q   <= d_q;
    end
  end

  // stage F: s squared
  logic [57:0]      s_sq;
  rmte_pkg::carry_t f_q;
  logic             f_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      s_sq <= ({30'b0, pp_hh} << 30) + ({29'b0, pp_hl} << 16) + {28'b0, pp_ll};
      f_q  <= e_q;
    end
  end

  // stage G: 1 - s*s in Q56
  logic [0:0][57:0] c_rad;
  logic [0:0][28:0] c_root;
  rmte_pkg::carry_t g_q;
  rmte_pkg::carry_t h_q;
  logic             g_vld;
  logic             h_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      c_rad[0] <= rmte_pkg::ONE_Q56 - s_sq;
      g_q      <= f_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else if (en) begin
      b_vld <= q_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  rmte_isqrt #(.IN_W(58), .LANES(1), .SIDE_W($bits(rmte_pkg::carry_t))) u_csqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(g_vld), .rad(c_rad), .side_in(g_q),
    .out_valid(h_vld), .root(c_root), .side_out(h_q)
  );

  // atan2 lanes: 0 roll, 1 pitch, 2 yaw
  logic [2:0][CW-1:0]  at_y, at_x;
  logic [2:0][ZW-1:0]  at_z;
  rmte_pkg::quat_t     at_q;
  logic                at_vld;

  always_comb begin
    at_y[0] = CW'(h_q.num_r);
    at_x[0] = CW'(h_q.den_r);
    at_y[1] = CW'(h_q.s);
    at_x[1] = CW'({1'b0, c_root[0]});
    at_y[2] = CW'(h_q.num_y);
    at_x[2] = CW'(h_q.den_y);
  end

  rmte_cordic #(.LANES(3), .SIDE_W($bits(rmte_pkg::quat_t))) u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(h_vld), .y_in(at_y), .x_in(at_x), .side_in(h_q.q),
    .out_valid(at_vld), .z_out(at_z), .side_out(at_q)
  );

  // output stage: round to Q13 and clamp
  logic signed [ZW-1:0] zs0, zs1, zs2;
  logic signed [17:0]   r0, r1, r2;

  always_comb begin
    zs0 = ($signed(at_z[0]) + 25'sd64) >>> 7;
    zs1 = ($signed(at_z[1]) + 25'sd64) >>> 7;
    zs2 = ($signed(at_z[2]) + 25'sd64) >>> 7;
    r0  = zs0[17:0];
    r1  = zs1[17:0];
    r2  = zs2[17:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_w <= at_q.w;
      quat_x <= at_q.x;
      quat_y <= at_q.y;
      quat_z <= at_q.z;
      if (r0 > rmte_pkg::ROLL_LIM) begin
        roll_angle <= 16'(rmte_pkg::ROLL_LIM);
      end else if (r0 < -rmte_pkg::ROLL_LIM) begin
        roll_angle <= 16'(-rmte_pkg::ROLL_LIM);
      end else begin
        roll_angle <= r0[15:0];
      end
      if (r1 > rmte_pkg::PITCH_LIM) begin
        pitch_angle <= 15'(rmte_pkg::PITCH_LIM);
      end else if (r1 < -rmte_pkg::PITCH_LIM) begin
        pitch_angle <= 15'(-rmte_pkg::PITCH_LIM);
      end else begin
        pitch_angle <= r1[14:0];
      end
      if (r2 > rmte_pkg::ROLL_LIM) begin
        yaw_angle <= 16'(rmte_pkg::ROLL_LIM);
      end else if (r2 < -rmte_pkg::ROLL_LIM) begin
        yaw_angle <= 16'(-rmte_pkg::ROLL_LIM);
      end else begin
        yaw_angle <= r2[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= at_vld;
    end
  end

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && at_vld) |=> at_vld && out_valid)
    else $error("pipeline lost an item while stalled");

endmodule

FILE: dv/rmte_checker.sv
module rmte_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [14:0]        quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] roll_angle,
  input  logic signed [14:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [14:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
  } pose_t;

  pose_t pose_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(rmte_pkg::PI_Q20) : -longint'(rmte_pkg::PI_Q20);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < rmte_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(rmte_pkg::ATAN_TAB[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(rmte_pkg::ATAN_TAB[i]);
      end
    end
    return (z + 64) >>> 7;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint magnitude(longint t);
    if (t < 0) t = 0;
    return longint'(int_sqrt(longint'(t) << 12));
  endfunction

  function automatic pose_t predict_pose(longint a00, a01, a02, a10, a11, a12,
                                         a20, a21, a22);
    longint w, x, y, z, s, one;
    longint unsigned c;
    pose_t p;
    one = 64'sd1 <<< 28;
    w = magnitude(16384 + a00 + a11 + a22);
    x = magnitude(16384 + a00 - a11 - a22);
    y = magnitude(16384 - a00 + a11 - a22);
    z = magnitude(16384 - a00 - a11 + a22);
    if (a21 - a12 < 0) x = -x;
    if (a02 - a20 < 0) y = -y;
    if (a10 - a01 < 0) z = -z;
    p.w = w[14:0];
    p.x = x[15:0];
    p.y = y[15:0];
    p.z = z[15:0];
    p.roll = 16'(sat(cordic_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y)), 25736));
    s = sat(2 * (w * y - z * x), one);
    c = int_sqrt((64'd1 << 56) - longint'(unsigned'(s * s)));
    p.pitch = 15'(sat(cordic_atan2(s, longint'(c)), 12868));
    p.yaw = 16'(sat(cordic_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z)), 25736));
    return p;
  endfunction

  pose_t got, exp_p;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        pose_q.push_back(predict_pose(m00, m01, m02, m10, m11, m12, m20, m21, m22));
      if (out_valid && out_ready) begin
        got = '{quat_w, quat_x, quat_y, quat_z, roll_angle, pitch_angle, yaw_angle};
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          exp_p = pose_q.pop_front();
          if (got !== exp_p) begin
            $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d r=%0d p=%0d y=%0d",
                     $time, exp_p.w, $signed(exp_p.x), $signed(exp_p.y),
                     $signed(exp_p.z), $signed(exp_p.roll), $signed(exp_p.pitch),
                     $signed(exp_p.yaw));
            $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d r=%0d p=%0d y=%0d",
                     $time, got.w, $signed(got.x), $signed(got.y), $signed(got.z),
                     $signed(got.roll), $signed(got.pitch), $signed(got.yaw));
            fail_count++;
          end
        end
      end
    end
    pending = pose_q.size();
  end
endmodule

FILE: dv/tb_rotation_matrix_to_euler_angles.sv
module tb_rotation_matrix_to_euler_angles;
  logic clk, rst, in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] m [9];
  logic [14:0] quat_w;
  logic signed [15:0] quat_x, quat_y, quat_z, roll_angle, yaw_angle;
  logic signed [14:0] pitch_angle;
  int fail_count, pending, cycle, sent;
  bit hold_req;

  rotation_matrix_to_euler_angles dut (
    .clk, .rst, .in_valid, .in_ready,
    .m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
    .m20(m[6]), .m21(m[7]), .m22(m[8]),
    .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z,
    .roll_angle, .pitch_angle, .yaw_angle
  );

  rmte_checker chk (
    .clk, .rst, .in_valid, .in_ready,
    .m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
    .m20(m[6]), .m21(m[7]), .m22(m[8]),
    .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z,
    .roll_angle, .pitch_angle, .yaw_angle, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit quiet_window();
    return cycle >= 1500 && cycle < 2300;
  endfunction

  // receiver
  initial begin
    out_ready = 0;
    cycle = 0;
    forever begin
      @(negedge clk);
      cycle++;
      if (hold_req) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_req = 0;
        cycle += 300;
      end else begin
        out_ready <= quiet_window() || ($urandom_range(99) >= 36);
      end
    end
  end

  task automatic send_matrix(input logic signed [15:0] v [9]);
    while (!quiet_window() && $urandom_range(99) < 36) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    for (int i = 0; i < 9; i++) m[i] <= v[i];
    do @(posedge clk); while (!in_ready);
    sent++;
    if (sent == 700) hold_req = 1;
  endtask

  // signed permutation matrix, optionally perturbed
  task automatic send_perm(input int jitter);
    logic signed [15:0] v [9];
    int p [3];
    int k;
    p = '{0, 1, 2};
    k = $urandom_range(5);
    if (k[0]) p = '{p[1], p[0], p[2]};
    if (k >= 2) p = '{p[1], p[2], p[0]};
    if (k >= 4) p = '{p[1], p[2], p[0]};
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        v[r*3+c] = (p[r] == c) ? ($urandom_range(1) ? 16'sd16384 : -16'sd16384) : 16'sd0;
    for (int i = 0; i < 9; i++)
      v[i] = v[i] + $signed(16'($urandom_range(2 * jitter) - jitter));
    send_matrix(v);
  endtask

  logic signed [15:0] vec [9];

  initial begin
    rst = 1;
    in_valid = 0;
    sent = 0;
    hold_req = 0;
    for (int i = 0; i < 9; i++) m[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    send_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
    send_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
    send_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
    send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
    send_matrix('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});
    send_matrix('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767});
    // pitch near and beyond +-90 degrees, asin saturates
    send_matrix('{0, 0, 16384, 0, 16384, 0, -16384, 0, 0});
    send_matrix('{0, 0, -16384, 0, 16384, 0, 16384, 0, 0});
    send_matrix('{16384, 0, 32767, 0, 16384, -32768, -32768, 32767, 16384});
    send_matrix('{16384, 32767, -32768, -32768, 16384, 32767, 32767, -32768, 16384});
    // 90 degree turns about the x and z axes
    send_matrix('{16384, 0, 0, 0, 0, -16384, 0, 16384, 0});
    send_matrix('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384});
    send_matrix('{0, 16384, 0, -16384, 0, 0, 0, 0, 16384});
    send_matrix('{16384, 5, 7, 5, 16384, 9, 7, 9, 16384});
    send_matrix('{0, 1, -1, 1, 0, 1, -1, 1, 0});

    repeat (1340) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_perm(4000);
        4, 5:       send_perm(40);
        6:          send_perm(0);
        default: begin
          for (int i = 0; i < 9; i++) vec[i] = 16'($urandom);
          send_matrix(vec);
        end
      endcase
    end
    @(negedge clk);
    in_valid <= 0;

    while (pending != 0 || hold_req) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/rmte_pkg.sv
rtl/core/rmte_isqrt.sv
rtl/core/rmte_cordic.sv
rtl/core/rotation_matrix_to_euler_angles.sv
dv/rmte_checker.sv
dv/tb_rotation_matrix_to_euler_angles.sv
